// ===== hdl/crfd_pkg.sv =====
// Shared types, field widths and operation codes for the CAN receive FIFO
// with id-matched mailboxes. No dependencies.
package crfd_pkg;

  localparam int FIFO_DEPTH   = 16;
  localparam int ID_W         = 11;
  localparam int BYTE_W       = 8;
  localparam int NUM_BYTES    = 8;
  localparam int PAYLOAD_W    = BYTE_W * NUM_BYTES;
  localparam int ENTRY_W      = ID_W + PAYLOAD_W;
  localparam int OP_W         = 2;
  localparam int OCC_W        = 4;
  localparam int WORD_W       = 16;
  localparam int MOTOR_W      = 3 * WORD_W;
  localparam int FRESH_W      = 2;
  localparam int CFG_INDEX_W  = 2;
  localparam int IN_TDATA_W   = 80;
  localparam int OUT_TDATA_W  = 128;

  localparam logic [OP_W-1:0] OP_RECEIVE = 2'd0;
  localparam logic [OP_W-1:0] OP_SERVICE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_JOG_ID     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ENCODER_ID = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MOTOR_A_ID = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MOTOR_B_ID = 2'd3;

  localparam logic [ID_W-1:0] JOG_ID_RESET     = 11'd1;
  localparam logic [ID_W-1:0] ENCODER_ID_RESET = 11'd2;
  localparam logic [ID_W-1:0] MOTOR_A_ID_RESET = 11'd3;
  localparam logic [ID_W-1:0] MOTOR_B_ID_RESET = 11'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // input word taken this cycle
    logic dispatch;  // RAM read data is valid, update mailboxes
    logic load_out;  // capture the result into the output register
  } crfd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_fetch;  // the offered word is a service request on a non-empty FIFO
  } crfd_status_t;

endpackage

// ===== hdl/crfd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered
// read data. No dependencies.
module crfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/crfd_ctrl.sv =====
// Controller state machine: input handshake, item sequencing and the output
// register's valid flag. Depends on crfd_pkg.
module crfd_ctrl
  import crfd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  output logic         m_tvalid,
  input  logic         m_tready,
  input  crfd_status_t status,
  output crfd_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_FETCH  = 2'd1;
  localparam logic [1:0] ST_RESULT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign s_tready     = (state == ST_IDLE);
  assign out_free     = !m_tvalid || m_tready;
  assign cmd.accept   = s_tvalid && s_tready;
  assign cmd.dispatch = (state == ST_FETCH);
  assign cmd.load_out = (state == ST_RESULT) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.accept) begin
          state_next = status.need_fetch ? ST_FETCH : ST_RESULT;
        end
      end
      ST_FETCH: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/crfd_datapath.sv =====
// Datapath: FIFO pointers and storage, occupancy and peak tracking, id match
// and mailbox registers, output register. Depends on crfd_pkg and crfd_ram.
module crfd_datapath
  import crfd_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  crfd_cmd_t              cmd,
  output crfd_status_t           status,
  input  logic [OP_W-1:0]        s_tuser,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [ID_W-1:0]        cfg_data,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_INDEX = AW'(DEPTH - 1);

  logic [AW-1:0]        wr_ptr;
  logic [AW-1:0]        rd_ptr;
  logic [AW-1:0]        peak;
  logic [AW-1:0]        occ;
  logic [AW-1:0]        occ_held;
  logic                 ovf_held;
  logic [AW:0]          occ_wide;
  logic                 full;
  logic                 push;
  logic                 pop;
  logic [ID_W-1:0]      frame_id;
  logic [PAYLOAD_W-1:0] payload;
  logic [ENTRY_W-1:0]   rd_entry;
  logic [ID_W-1:0]      rd_id;
  logic [PAYLOAD_W-1:0] rd_payload;

  logic [ID_W-1:0]      jog_id;
  logic [ID_W-1:0]      encoder_id;
  logic [ID_W-1:0]      motor_a_id;
  logic [ID_W-1:0]      motor_b_id;
  logic [BYTE_W-1:0]    jog;
  logic [BYTE_W-1:0]    encoder;
  logic [FRESH_W-1:0]   fresh;
  logic [MOTOR_W-1:0]   motor_a;
  logic [MOTOR_W-1:0]   motor_b;

  assign frame_id = s_tdata[ID_W-1:0];
  assign payload  = s_tdata[ID_W +: PAYLOAD_W];

  // Pointers wrap at DEPTH, which need not be a power of two.
  assign occ_wide = {1'b0, wr_ptr} + (AW + 1)'(DEPTH) - {1'b0, rd_ptr};
  assign occ      = (wr_ptr >= rd_ptr) ? (wr_ptr - rd_ptr) : occ_wide[AW-1:0];
  assign full     = (occ >= LAST_INDEX);

  assign push = cmd.accept && (s_tuser == OP_RECEIVE) && !full;
  assign pop  = cmd.accept && (s_tuser == OP_SERVICE) && (occ != '0);
  assign status.need_fetch = (s_tuser == OP_SERVICE) && (occ != '0);

  crfd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (wr_ptr),
    .wr_data ({payload, frame_id}),
    .rd_en   (pop),
    .rd_addr (rd_ptr),
    .rd_data (rd_entry)
  );

  assign rd_id      = rd_entry[ID_W-1:0];
  assign rd_payload = rd_entry[ID_W +: PAYLOAD_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      peak       <= '0;
      jog        <= '0;
      encoder    <= '0;
      fresh      <= '0;
      motor_a    <= '0;
      motor_b    <= '0;
      jog_id     <= JOG_ID_RESET;
      encoder_id <= ENCODER_ID_RESET;
      motor_a_id <= MOTOR_A_ID_RESET;
      motor_b_id <= MOTOR_B_ID_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_JOG_ID:     jog_id     <= cfg_data;
          REG_ENCODER_ID: encoder_id <= cfg_data;
          REG_MOTOR_A_ID: motor_a_id <= cfg_data;
          REG_MOTOR_B_ID: motor_b_id <= cfg_data;
          default: ;
        endcase
      end
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_INDEX) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_INDEX) ? '0 : rd_ptr + 1'b1;
      end
      if (cmd.accept && (s_tuser == OP_SERVICE) && (occ > peak)) begin
        peak <= occ;
      end
      if (cmd.accept && (s_tuser == OP_CLEAR)) begin
        fresh <= '0;
      end
      // First matching id in register order wins. Words are little-endian
      // byte pairs, so they sit in the payload already in place.
      if (cmd.dispatch) begin
        if (rd_id == jog_id) begin
          jog      <= rd_payload[BYTE_W-1:0];
          fresh[0] <= 1'b1;
        end else if (rd_id == encoder_id) begin
          encoder  <= rd_payload[BYTE_W-1:0];
          fresh[1] <= 1'b1;
        end else if (rd_id == motor_a_id) begin
          motor_a <= rd_payload[MOTOR_W-1:0];
        end else if (rd_id == motor_b_id) begin
          motor_b <= rd_payload[PAYLOAD_W-1:WORD_W];
        end
      end
    end
  end

  // Per-item result fields, captured at acceptance.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      occ_held <= occ;
      ovf_held <= (s_tuser == OP_RECEIVE) && full;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {5'd0, ovf_held, OCC_W'(peak), OCC_W'(occ_held), motor_b, motor_a,
                  fresh, encoder, jog};
    end
  end

endmodule

// ===== hdl/can_rx_fifo_id_dispatch_unit.sv =====
// Top level of the CAN receive FIFO with id-matched mailboxes.
// Depends on crfd_pkg, crfd_ctrl, crfd_datapath (and through it crfd_ram).
//
//  Channel  | Direction | Signals                         | Word content
//  ---------+-----------+---------------------------------+------------------------------
//  s_       | in        | s_tvalid s_tready s_tdata s_tuser | one request: receive, service
//           |           |                                 | or clear fresh flags
//  m_       | out       | m_tvalid m_tready m_tdata       | mailbox snapshot after the
//           |           |                                 | request, occupancy, overflow
//  cfg_     | in        | cfg_we cfg_index cfg_data       | id match register write
//
// A receive, clear or empty-FIFO service request passes through the result
// state after acceptance before the next word can be accepted; a service
// request that pops a frame first passes through the fetch state, the
// registered read of the frame RAM before the mailboxes are updated.
// The output register holds a finished result while a new input word is
// accepted; a stalled output only holds up the next result from being loaded.
// Reset is synchronous: pointers, peak, mailboxes and fresh flags clear and the
// id registers return to 1, 2, 3 and 4. The frame RAM is not cleared; entries
// are read only after they were written.
// A receive request that finds DEPTH-1 frames held is dropped and flagged.
module can_rx_fifo_id_dispatch_unit
  import crfd_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // Bits from low: frame_id[10:0], byte_0[18:11], byte_1, ... byte_7[74:67], zeros.
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // Bits: operation[1:0].
  input  logic [OP_W-1:0]        s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // Bits from low: jog_value[7:0], encoder_value[15:8], fresh_flags[17:16],
  // motor_speed[33:18], motor_current[49:34], motor_position[65:50],
  // motor_voltage[81:66], motor_temp_first[97:82], motor_temp_second[113:98],
  // occupancy[117:114], peak_occupancy[121:118], overflow[122], zeros.
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [ID_W-1:0]        cfg_data
);

  crfd_cmd_t    cmd;
  crfd_status_t status;

  // The controller sequences each word; the datapath owns all storage.
  crfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  crfd_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tdata   (m_tdata)
  );

endmodule

// ===== hdl/crfd_props.sv =====
// Port-level assertions for the CAN receive FIFO top level, bound to it.
// Depends on crfd_pkg and can_rx_fifo_id_dispatch_unit.
module crfd_props
  import crfd_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH - 1);

  // A dropped frame is only reported when the FIFO held DEPTH-1 frames.
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[122]) |-> (m_tdata[117:114] == FULL_OCC))
    else $error("overflow reported below full occupancy");

  // One word at a time: the input closes right after an acceptance.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a word is in progress");

  // A new result only appears while the input side is closed.
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared without work in progress");

  // Leaving reset: no result pending and the input open.
  a_reset_state: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready))
    else $error("bad state after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled output word changed");

endmodule

bind can_rx_fifo_id_dispatch_unit crfd_props #(.DEPTH(DEPTH)) u_props (.*);

// ===== tb/can_rx_fifo_checker.sv =====
// Scoreboard for the CAN receive FIFO with id-matched mailboxes: predicts
// every result word from the accepted request words and id writes, then
// compares. Depends on crfd_pkg.
module can_rx_fifo_checker
  import crfd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic [OP_W-1:0]        s_tuser,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [ID_W-1:0]        cfg_data,
  output int                     mismatches,
  output int                     outstanding,
  output int                     words_checked,
  output int                     drops_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int SNAP_W = 123;

  // Field order from the top bit down, so a cast of m_tdata[122:0] lines up.
  typedef struct packed {
    logic                 overflow;
    logic [OCC_W-1:0]     peak;
    logic [OCC_W-1:0]     occupancy;
    logic [WORD_W-1:0]    temp_second;
    logic [WORD_W-1:0]    temp_first;
    logic [WORD_W-1:0]    voltage;
    logic [WORD_W-1:0]    position;
    logic [WORD_W-1:0]    current;
    logic [WORD_W-1:0]    speed;
    logic [FRESH_W-1:0]   fresh;
    logic [BYTE_W-1:0]    encoder;
    logic [BYTE_W-1:0]    jog;
  } snapshot_t;

  logic [ID_W-1:0]      match_ids [4];
  logic [ID_W-1:0]      held_ids  [FIFO_DEPTH];
  logic [PAYLOAD_W-1:0] held_data [FIFO_DEPTH];
  logic [PTR_W-1:0]     wr_ptr, rd_ptr;
  logic [OCC_W-1:0]     peak_held;
  logic [BYTE_W-1:0]    jog_byte, encoder_byte;
  logic [FRESH_W-1:0]   fresh_bits;
  logic [MOTOR_W-1:0]   motor_a, motor_b;

  snapshot_t expected_snapshots [$];
  int        err_count;
  int        checked_count;
  int        drop_count;

  // Applies one request to the shadow FIFO and mailboxes and returns the
  // snapshot the block should report for it.
  function automatic snapshot_t apply_request(input logic [OP_W-1:0] op,
                                              input logic [ID_W-1:0] id,
                                              input logic [PAYLOAD_W-1:0] data);
    snapshot_t        snap;
    logic [PTR_W-1:0] held;
    logic [ID_W-1:0]  pop_id;
    logic [PAYLOAD_W-1:0] pop_data;
    held = wr_ptr - rd_ptr;
    snap = '0;
    case (op)
      OP_RECEIVE: begin
        // One slot always stays empty, so DEPTH-1 held frames means full.
        if (int'(held) >= FIFO_DEPTH - 1) begin
          snap.overflow = 1'b1;
        end else begin
          held_ids[wr_ptr]  = id;
          held_data[wr_ptr] = data;
          wr_ptr = wr_ptr + 1'b1;
        end
      end
      OP_SERVICE: begin
        if (OCC_W'(held) > peak_held) peak_held = OCC_W'(held);
        if (held != '0) begin
          pop_id   = held_ids[rd_ptr];
          pop_data = held_data[rd_ptr];
          rd_ptr   = rd_ptr + 1'b1;
          // Register order decides when several ids are equal.
          if (pop_id == match_ids[REG_JOG_ID]) begin
            jog_byte   = pop_data[7:0];
            fresh_bits = fresh_bits | 2'b01;
          end else if (pop_id == match_ids[REG_ENCODER_ID]) begin
            encoder_byte = pop_data[7:0];
            fresh_bits   = fresh_bits | 2'b10;
          end else if (pop_id == match_ids[REG_MOTOR_A_ID]) begin
            motor_a = pop_data[47:0];
          end else if (pop_id == match_ids[REG_MOTOR_B_ID]) begin
            motor_b = pop_data[63:16];
          end
        end
      end
      OP_CLEAR: fresh_bits = '0;
      default: ;
    endcase
    snap.jog         = jog_byte;
    snap.encoder     = encoder_byte;
    snap.fresh       = fresh_bits;
    snap.speed       = motor_a[15:0];
    snap.current     = motor_a[31:16];
    snap.position    = motor_a[47:32];
    snap.voltage     = motor_b[15:0];
    snap.temp_first  = motor_b[31:16];
    snap.temp_second = motor_b[47:32];
    snap.occupancy   = OCC_W'(held);
    snap.peak        = peak_held;
    return snap;
  endfunction

  task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    snapshot_t got, want;
    if (rst) begin
      match_ids[REG_JOG_ID]     = JOG_ID_RESET;
      match_ids[REG_ENCODER_ID] = ENCODER_ID_RESET;
      match_ids[REG_MOTOR_A_ID] = MOTOR_A_ID_RESET;
      match_ids[REG_MOTOR_B_ID] = MOTOR_B_ID_RESET;
      wr_ptr       = '0;
      rd_ptr       = '0;
      peak_held    = '0;
      jog_byte     = '0;
      encoder_byte = '0;
      fresh_bits   = '0;
      motor_a      = '0;
      motor_b      = '0;
      expected_snapshots.delete();
    end else begin
      if (cfg_we) match_ids[cfg_index] = cfg_data;
      if (m_tvalid && m_tready) begin
        got = snapshot_t'(m_tdata[SNAP_W-1:0]);
        if (expected_snapshots.size() == 0) begin
          $error("result word 0x%0h arrived with no request outstanding", m_tdata);
          err_count++;
        end else begin
          want = expected_snapshots.pop_front();
          check_field("jog_value", want.jog, got.jog);
          check_field("encoder_value", want.encoder, got.encoder);
          check_field("fresh_flags", want.fresh, got.fresh);
          check_field("motor_speed", want.speed, got.speed);
          check_field("motor_current", want.current, got.current);
          check_field("motor_position", want.position, got.position);
          check_field("motor_voltage", want.voltage, got.voltage);
          check_field("motor_temp_first", want.temp_first, got.temp_first);
          check_field("motor_temp_second", want.temp_second, got.temp_second);
          check_field("occupancy", want.occupancy, got.occupancy);
          check_field("peak_occupancy", want.peak, got.peak);
          check_field("overflow", want.overflow, got.overflow);
          checked_count++;
          if (want.overflow) drop_count++;
        end
      end
      if (s_tvalid && s_tready)
        expected_snapshots.push_back(apply_request(s_tuser, s_tdata[ID_W-1:0],
                                                   s_tdata[ID_W +: PAYLOAD_W]));
    end
    // Registered copies, so the stimulus side always sees last edge's values.
    outstanding   <= expected_snapshots.size();
    mismatches    <= err_count;
    words_checked <= checked_count;
    drops_seen    <= drop_count;
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the testbench for can_rx_fifo_id_dispatch_unit: clock, reset,
// request stimulus, output back-pressure and the verdict. Depends on
// crfd_pkg, the block itself and can_rx_fifo_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import crfd_pkg::*;

  // The package names three operations; the fourth code must be a no-op.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // A popping service passes through the fetch and result states, so DRAIN_CYCLES
  // idle cycles are plenty to let the block come to rest before an id register is rewritten.
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 300;
  // Watchdog limit, far beyond what the slowest legal run needs.
  localparam int CYCLE_LIMIT  = 400_000;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  // Bits from low: frame_id[10:0], byte_0[18:11] .. byte_7[74:67], zeros.
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  // Bits: operation[1:0].
  logic [OP_W-1:0]        s_tuser   = OP_RECEIVE;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  // Bits from low: jog_value, encoder_value, fresh_flags, motor_speed,
  // motor_current, motor_position, motor_voltage, motor_temp_first,
  // motor_temp_second, occupancy, peak_occupancy, overflow, zeros.
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_JOG_ID;
  logic [ID_W-1:0]        cfg_data  = '0;

  int mismatches;
  int outstanding;
  int words_checked;
  int drops_seen;

  int cycle_count = 0;
  int words_sent  = 0;
  int burst_left  = 0;
  int id_settings = 1;
  int holds_done  = 0;
  bit hold_off_req = 1'b0;

  // Our copy of the match ids, used only to steer random frames onto them.
  logic [ID_W-1:0] cur_ids [4] = '{JOG_ID_RESET, ENCODER_ID_RESET,
                                   MOTOR_A_ID_RESET, MOTOR_B_ID_RESET};

  can_rx_fifo_id_dispatch_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  can_rx_fifo_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog: if the block hangs, the run still ends with a verdict.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Timed out after %0d cycles with %0d results outstanding",
             cycle_count, outstanding);
    $display("Regression FAIL");
    $finish;
  end

  // Output side back-pressure. It wanders between always-ready, coin-flip,
  // mostly-stalled and periodic patterns. On request it holds off once for a
  // long stretch so the output register fills and the block stalls its input.
  initial begin : rx_side
    int mode;
    int span;
    mode = 0;
    span = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req && (holds_done == 0)) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done++;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(20, 200);
        end
        span--;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ((cycle_count % 5) != 0);
        endcase
      end
    end
  end

  // Offers one request word and waits for it to be taken. Words go out in
  // bursts of random length; between bursts the valid drops for a random gap,
  // and some bursts run straight into the next with no gap at all.
  task automatic offer(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                       input logic [PAYLOAD_W-1:0] data);
    int gap;
    s_tuser  <= op;
    s_tdata  <= {{(IN_TDATA_W - ID_W - PAYLOAD_W){1'b0}}, data, id};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stops offering and waits until every result has come back, then idles
  // for DRAIN_CYCLES so the block can settle.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [ID_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    cur_ids[idx] = val;
    @(posedge clk);
  endtask

  // Rewrites all four match ids while the block is idle.
  task automatic write_ids(input logic [ID_W-1:0] jog, input logic [ID_W-1:0] enc,
                           input logic [ID_W-1:0] mot_a, input logic [ID_W-1:0] mot_b);
    settle();
    cfg_write(REG_JOG_ID, jog);
    cfg_write(REG_ENCODER_ID, enc);
    cfg_write(REG_MOTOR_A_ID, mot_a);
    cfg_write(REG_MOTOR_B_ID, mot_b);
    cfg_we <= 1'b0;
    @(posedge clk);
    id_settings++;
  endtask

  // Most frames carry one of the live match ids so the mailboxes get work;
  // the rest are arbitrary and usually fall through unmatched.
  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 9) < 6) return cur_ids[$urandom_range(0, 3)];
    return ID_W'($urandom());
  endfunction

  function automatic logic [PAYLOAD_W-1:0] pick_payload();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Random traffic. Fill runs push a block of frames and then drain them,
  // which walks the FIFO to full and past it; mixed runs interleave every
  // operation with a bias toward receive and service.
  task automatic run_random(input int count);
    int stop_at;
    int len;
    int pick;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 9) < 3) begin
        len = $urandom_range(8, 20);
        repeat (len) offer(OP_RECEIVE, pick_id(), pick_payload());
        repeat (len) offer(OP_SERVICE, ID_W'($urandom()), pick_payload());
      end else begin
        len = $urandom_range(5, 40);
        repeat (len) begin
          pick = $urandom_range(0, 99);
          if (pick < 45)      offer(OP_RECEIVE, pick_id(), pick_payload());
          else if (pick < 90) offer(OP_SERVICE, ID_W'($urandom()), pick_payload());
          else if (pick < 97) offer(OP_CLEAR, ID_W'($urandom()), pick_payload());
          else                offer(OP_UNUSED, ID_W'($urandom()), pick_payload());
        end
      end
    end
  endtask

  initial begin : stimulus
    logic [ID_W-1:0] rand_ids [4];
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed start on the reset ids. A service on an empty FIFO, the
    // unused operation and a clear all come first, then one frame for each
    // mailbox with extreme bytes and signed extremes in the words, two
    // unmatched frames, and enough services to drain and hit empty again.
    offer(OP_SERVICE, '0, '0);
    offer(OP_UNUSED, '1, '1);
    offer(OP_CLEAR, '0, '0);
    offer(OP_RECEIVE, JOG_ID_RESET, '1);
    offer(OP_RECEIVE, ENCODER_ID_RESET, '0);
    offer(OP_RECEIVE, MOTOR_A_ID_RESET, {16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000});
    offer(OP_RECEIVE, MOTOR_B_ID_RESET, {16'h8000, 16'h7FFF, 16'hFFFF, 16'h5AA5});
    offer(OP_RECEIVE, 11'h7FF, {$urandom(), $urandom()});
    offer(OP_RECEIVE, 11'h000, {$urandom(), $urandom()});
    repeat (7) offer(OP_SERVICE, ID_W'($urandom()), {$urandom(), $urandom()});
    offer(OP_CLEAR, '0, '0);
    offer(OP_SERVICE, '0, '0);

    // Extreme ids, with one long output hold-off while requests keep coming.
    write_ids(11'h000, 11'h7FF, 11'h555, 11'h2AA);
    hold_off_req = 1'b1;
    run_random(400);

    // All ids equal: the jog register must win every match.
    write_ids(11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF);
    run_random(120);
    // Partial overlap: encoder beats motor A, jog beats motor B.
    write_ids(11'h123, 11'h555, 11'h555, 11'h123);
    run_random(130);

    repeat (3) begin
      foreach (rand_ids[r]) rand_ids[r] = ID_W'($urandom());
      if ($urandom_range(0, 2) == 0) rand_ids[3] = rand_ids[$urandom_range(0, 2)];
      write_ids(rand_ids[0], rand_ids[1], rand_ids[2], rand_ids[3]);
      run_random(300);
    end

    write_ids(JOG_ID_RESET, ENCODER_ID_RESET, MOTOR_A_ID_RESET, MOTOR_B_ID_RESET);
    run_random(100);

    settle();
    repeat (4 * DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d request words and checked %0d result words over %0d id settings,",
             words_sent, words_checked, id_settings);
    $display("with %0d frames dropped on a full FIFO and %0d long output hold-off(s).",
             drops_seen, holds_done);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
